### src/tpg_pkg.sv
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared widths, reset values and codes for the trigger pulse generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

    localparam int MS_W    = 15;   // millisecond fields
    localparam int CNT_W   = 11;   // tick counters
    localparam int SERVO_W = 16;   // servo pulse widths
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int TICK_MS_DEFAULT = 25;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // register reset values
    localparam logic              RST_ENABLED      = 1'b1;
    localparam logic [MS_W-1:0]   RST_PULSE_MS     = 15'd250;
    localparam logic [MS_W-1:0]   RST_REPEAT_MS    = 15'd1000;
    localparam logic [SERVO_W-1:0] RST_SERVO_HIGH  = 16'd4000;
    localparam logic [SERVO_W-1:0] RST_SERVO_LOW   = 16'd2000;

    typedef enum logic [MODE_W-1:0] {
        MODE_PULSE_HIGH = 2'd0,
        MODE_PULSE_LOW  = 2'd1,
        MODE_TOGGLE     = 2'd2,
        MODE_REPEAT     = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED    = 3'd0,
        CFG_MODE       = 3'd1,
        CFG_PULSE_MS   = 3'd2,
        CFG_REPEAT_MS  = 3'd3,
        CFG_SERVO_HIGH = 3'd4,
        CFG_SERVO_LOW  = 3'd5
    } t_cfg_idx;

endpackage

### src/trigger_pulse_generator.sv
// ----------------------------------------------------------------------------
// trigger_pulse_generator
// Tick-driven trigger: an activation request opens a window of ticks, start
// and stop countdowns drive the action level per the selected mode.
// ----------------------------------------------------------------------------
// Path: an input beat reaches the result through the input register, then the
//   result register that also updates the tick state.
// Throughput: one beat per cycle while the result is not stalled; ms-to-tick
//   conversion is a single constant-reciprocal multiply per field, no iteration.
// Reset (i_rst_n low, synchronous): both stages empty, counters and level
//   cleared, config registers back to defaults. No clearing pass.
module trigger_pulse_generator
    import tpg_pkg::*;
#(
    parameter int TICK_MS = TICK_MS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [MS_W-1:0]       i_request_ms,

    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_action_level,
    output logic                  o_window_active,
    output logic [SERVO_W-1:0]    o_servo_width
);

    // exact floor(ms / TICK_MS) for any MS_W-bit ms: round-up reciprocal with
    // MS_W + ceil(log2(TICK_MS)) fraction bits
    localparam int SHIFT   = MS_W + $clog2(TICK_MS);
    localparam int RECIP_W = MS_W + 2;
    localparam int PROD_W  = MS_W + RECIP_W;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + TICK_MS - 1) / TICK_MS;

    function automatic logic [CNT_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quo;
        prod = PROD_W'(ms) * PROD_W'(RECIP);
        quo  = prod >> SHIFT;
        if (quo > PROD_W'(CNT_MAX))
            return CNT_MAX;
        return quo[CNT_W-1:0];
    endfunction

    // configuration registers
    logic                r_enabled;
    t_mode               r_mode;
    logic [MS_W-1:0]     r_pulse_ms;
    logic [MS_W-1:0]     r_repeat_ms;
    logic [SERVO_W-1:0]  r_servo_high;
    logic [SERVO_W-1:0]  r_servo_low;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= RST_ENABLED;
            r_mode       <= MODE_PULSE_HIGH;
            r_pulse_ms   <= RST_PULSE_MS;
            r_repeat_ms  <= RST_REPEAT_MS;
            r_servo_high <= RST_SERVO_HIGH;
            r_servo_low  <= RST_SERVO_LOW;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLED:    r_enabled    <= i_cfg_data[0];
                CFG_MODE:       r_mode       <= t_mode'(i_cfg_data[MODE_W-1:0]);
                CFG_PULSE_MS:   r_pulse_ms   <= i_cfg_data[MS_W-1:0];
                CFG_REPEAT_MS:  r_repeat_ms  <= i_cfg_data[MS_W-1:0];
                CFG_SERVO_HIGH: r_servo_high <= i_cfg_data[SERVO_W-1:0];
                CFG_SERVO_LOW:  r_servo_low  <= i_cfg_data[SERVO_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    logic            r_in_valid;
    logic [MS_W-1:0] r_req;
    logic            out_free;
    logic            advance;

    assign out_free = !o_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_request_ms;
        end
    end

    // tick state
    logic [CNT_W-1:0] r_window;
    logic [CNT_W-1:0] r_start;
    logic [CNT_W-1:0] r_stop;
    logic             r_level;

    logic [CNT_W-1:0] n_window;
    logic [CNT_W-1:0] n_start;
    logic [CNT_W-1:0] n_stop;
    logic             n_level;
    logic             n_flag;
    logic [CNT_W-1:0] win_load;
    logic [CNT_W-1:0] pulse_ticks;
    logic [CNT_W-1:0] repeat_ticks;

    assign pulse_ticks  = ms_to_ticks(r_pulse_ms);
    assign repeat_ticks = ms_to_ticks(r_repeat_ms);

    always_comb begin
        n_level = r_level;
        n_stop  = r_stop;

        win_load = (r_enabled && (r_req != '0)) ? ms_to_ticks(r_req) : r_window;

        if (win_load != '0) begin
            n_flag   = 1'b1;
            n_start  = (r_start == '0) ? CNT_W'(1) : r_start;
            n_window = win_load - CNT_W'(1);
        end else begin
            n_flag   = 1'b0;
            n_start  = '0;
            n_window = '0;
            n_level  = 1'b0;
        end

        // stop countdown runs even with the window closed
        if (r_stop == CNT_W'(1)) begin
            n_level = (r_mode != MODE_PULSE_HIGH);
            n_stop  = '0;
        end else if (r_stop != '0) begin
            n_stop = r_stop - CNT_W'(1);
        end

        if (n_start == CNT_W'(1) && n_flag) begin
            case (r_mode)
                MODE_PULSE_HIGH, MODE_PULSE_LOW: begin
                    n_level = (r_mode == MODE_PULSE_HIGH);
                    n_stop  = pulse_ticks;
                    n_start = '0;
                end
                MODE_TOGGLE: begin
                    n_level = !n_level;
                    n_stop  = '0;
                    n_start = '0;
                end
                default: begin
                    n_level = 1'b0;
                    n_stop  = pulse_ticks;
                    n_start = repeat_ticks;
                end
            endcase
        end else if (n_start != '0) begin
            n_start = n_start - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_start  <= '0;
            r_stop   <= '0;
            r_level  <= 1'b0;
        end else if (advance) begin
            r_window <= n_window;
            r_start  <= n_start;
            r_stop   <= n_stop;
            r_level  <= n_level;
        end
    end

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_action_level  <= n_level;
            o_window_active <= n_flag;
            o_servo_width   <= n_level ? r_servo_high : r_servo_low;
        end
    end

    assign o_valid = r_out_valid;

endmodule

### src/tpg_checker.sv
// ----------------------------------------------------------------------------
// tpg_checker
// Port-level checks for the trigger pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
module tpg_checker
    import tpg_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic                  o_action_level,
    input logic                  o_window_active,
    input logic [SERVO_W-1:0]    o_servo_width
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_action_level)
            && $stable(o_window_active) && $stable(o_servo_width))
        else $error("result beat changed while stalled");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a fresh result comes from an input beat accepted through the input register
    a_rose_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result appeared without a matching input beat");

endmodule

bind trigger_pulse_generator tpg_checker u_tpg_checker (.*);
